### src/ssd_pkg.sv
// ----------------------------------------------------------------------------
// ssd_pkg: shared types, constants and glyph map
// Word formats, item kinds, frame and queue sizes, and the ASCII to
// active-low segment mapping used by the seven-segment serial driver.
// ----------------------------------------------------------------------------
package ssd_pkg;

    localparam int FRAME_BITS  = 16;
    localparam int FRAME_CNT_W = $clog2(FRAME_BITS);
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam logic [1:0] KIND_WRITE   = 2'd0;
    localparam logic [1:0] KIND_REFRESH = 2'd1;
    localparam logic [1:0] KIND_CLEAR   = 2'd2;

    localparam logic [7:0] CHAR_SPACE  = 8'h20;
    localparam logic [7:0] SEL_DIGIT0  = 8'h10;
    localparam logic [7:0] SEG_UNKNOWN = 8'd182;

    typedef logic [FRAME_BITS-1:0] t_frame;

    typedef struct packed {
        logic [1:0] kind;
        logic [1:0] digit;
        logic [7:0] char_code;
    } t_in_word;

    typedef struct packed {
        logic serial_bit;
        logic latch_after;
    } t_out_word;

    typedef struct packed {
        logic   valid;
        t_frame frame;
    } t_q_push;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    function automatic logic [7:0] glyph_num(input logic [3:0] idx);
        logic [7:0] g;
        case (idx)
            4'd0:    g = 8'hFC;
            4'd1:    g = 8'h60;
            4'd2:    g = 8'hDA;
            4'd3:    g = 8'hF2;
            4'd4:    g = 8'h66;
            4'd5:    g = 8'hB6;
            4'd6:    g = 8'h3E;
            4'd7:    g = 8'hE0;
            4'd8:    g = 8'hFE;
            4'd9:    g = 8'hE6;
            default: g = 8'h00;
        endcase
        return g;
    endfunction

    function automatic logic [7:0] glyph_letter(input logic [4:0] idx);
        logic [7:0] g;
        case (idx)
            5'd0:    g = 8'hEE;
            5'd1:    g = 8'hFE;
            5'd2:    g = 8'h9C;
            5'd3:    g = 8'hFC;
            5'd4:    g = 8'h9E;
            5'd5:    g = 8'h8E;
            5'd6:    g = 8'hBE;
            5'd7:    g = 8'h6E;
            5'd8:    g = 8'h0C;
            5'd9:    g = 8'h78;
            5'd10:   g = 8'h00;
            5'd11:   g = 8'h1C;
            5'd12:   g = 8'hEC;
            5'd13:   g = 8'h2E;
            5'd14:   g = 8'h3A;
            5'd15:   g = 8'hCE;
            5'd16:   g = 8'h3B;
            5'd17:   g = 8'hEE;
            5'd18:   g = 8'hB6;
            5'd19:   g = 8'h0E;
            5'd20:   g = 8'h7C;
            5'd21:   g = 8'h38;
            5'd22:   g = 8'h38;
            5'd23:   g = 8'h00;
            5'd24:   g = 8'h66;
            5'd25:   g = 8'hDA;
            default: g = 8'h00;
        endcase
        return g;
    endfunction

    // ASCII code to active-low segment pattern
    function automatic logic [7:0] map_code(input logic [7:0] c);
        logic [7:0] seg;
        logic [7:0] off_num;
        logic [7:0] off_lo;
        logic [7:0] off_up;
        off_num = c - 8'h30;
        off_lo  = c - 8'h61;
        off_up  = c - 8'h41;
        if (c >= 8'h30 && c <= 8'h39) begin
            seg = ~glyph_num(off_num[3:0]);
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            seg = ~glyph_letter(off_lo[4:0]);
        end else if (c >= 8'h41 && c <= 8'h5A) begin
            seg = ~glyph_letter(off_up[4:0]);
        end else begin
            case (c)
                8'h2D:   seg = ~8'h02;  // dash
                8'h2E:   seg = ~8'h01;  // dot
                8'h5F:   seg = ~8'h10;  // underscore
                8'h20:   seg = 8'hFF;   // blank
                default: seg = SEG_UNKNOWN;
            endcase
        end
        return seg;
    endfunction

endpackage

### src/ssd_front.sv
// ----------------------------------------------------------------------------
// ssd_front: item intake and frame build
// Holds the four display cells and the scan digit; turns refresh and clear
// items into 16-bit frames pushed into the frame queue.
// ----------------------------------------------------------------------------
module ssd_front
    import ssd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_accept,
    input  t_in_word  i_word,
    output t_q_push   o_q_push
);

    logic [7:0] r_cells [4];
    logic [7:0] n_cells [4];
    logic [1:0] r_scan;
    logic [1:0] n_scan;
    logic [7:0] w_sel;
    logic [7:0] w_seg;

    assign w_sel = SEL_DIGIT0 << r_scan;
    assign w_seg = map_code(r_cells[r_scan]);

    always_comb begin
        n_cells        = r_cells;
        n_scan         = r_scan;
        o_q_push.valid = 1'b0;
        o_q_push.frame = '0;
        if (i_accept) begin
            case (i_word.kind)
                KIND_WRITE: begin
                    n_cells[i_word.digit] = i_word.char_code;
                end
                KIND_REFRESH: begin
                    o_q_push.valid = 1'b1;
                    o_q_push.frame = {w_sel, w_seg};
                    n_scan         = r_scan + 2'd1;
                end
                KIND_CLEAR: begin
                    o_q_push.valid = 1'b1;
                end
                default: begin
                    // unused kind: dropped
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 4; i++) begin
                r_cells[i] <= CHAR_SPACE;
            end
            r_scan <= 2'd0;
        end else begin
            r_cells <= n_cells;
            r_scan  <= n_scan;
        end
    end

endmodule

### src/ssd_queue.sv
// ----------------------------------------------------------------------------
// ssd_queue: frame queue
// Small register queue of pending frames between intake and shift-out.
// ----------------------------------------------------------------------------
module ssd_queue
    import ssd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_q_push   i_q_push,
    input  logic      i_q_pop,
    output t_frame    o_frame,
    output t_q_status o_status
);

    t_frame              r_slots [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr;
    logic [QUEUE_AW-1:0] r_rd_ptr;
    logic [QUEUE_AW:0]   r_count;
    logic [QUEUE_AW:0]   n_count;

    assign o_frame         = r_slots[r_rd_ptr];
    assign o_status.full   = (r_count == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_status.empty  = (r_count == '0);

    always_comb begin
        n_count = r_count;
        if (i_q_push.valid && !i_q_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_q_push.valid && i_q_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_q_push.valid) begin
            r_slots[r_wr_ptr] <= i_q_push.frame;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_q_push.valid) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_q_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

endmodule

### src/ssd_back.sv
// ----------------------------------------------------------------------------
// ssd_back: serial shift-out
// Loads a frame from the queue and presents it one bit per word, LSB
// first, flagging the last bit for the store latch.
// ----------------------------------------------------------------------------
module ssd_back
    import ssd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_frame     i_frame,
    input  t_q_status  i_q_status,
    output logic       o_q_pop,
    input  logic       pop,
    output logic       empty,
    output t_out_word  o_word
);

    localparam logic [FRAME_CNT_W-1:0] LAST_BIT = FRAME_CNT_W'(FRAME_BITS - 1);

    t_frame                 r_shift;
    t_frame                 n_shift;
    logic [FRAME_CNT_W-1:0] r_cnt;
    logic [FRAME_CNT_W-1:0] n_cnt;
    logic                   r_busy;
    logic                   n_busy;
    logic                   w_last;
    logic                   w_load;

    assign w_last             = (r_cnt == LAST_BIT);
    assign w_load             = !i_q_status.empty && (!r_busy || (pop && w_last));
    assign o_q_pop            = w_load;
    assign empty              = !r_busy;
    assign o_word.serial_bit  = r_shift[0];
    assign o_word.latch_after = w_last;

    always_comb begin
        n_shift = r_shift;
        n_cnt   = r_cnt;
        n_busy  = r_busy;
        if (w_load) begin
            n_shift = i_frame;
            n_cnt   = '0;
            n_busy  = 1'b1;
        end else if (r_busy && pop) begin
            if (w_last) begin
                n_busy = 1'b0;
            end else begin
                n_shift = r_shift >> 1;
                n_cnt   = r_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_shift <= n_shift;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_busy <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_busy <= n_busy;
        end
    end

endmodule

### src/seven_segment_mux_serial_driver.sv
// ----------------------------------------------------------------------------
// seven_segment_mux_serial_driver: 4-digit 7-segment serial driver
// Multiplexed display driver feeding two chained shift registers.
// ----------------------------------------------------------------------------
// Usage:
//   Input queue (push/full, i_word): a write word stores char_code in cell
//   digit; a refresh word builds {digit select, segments} for the current
//   scan digit and advances the scan; a clear word builds an all-zero frame.
//   Kind 3 is accepted and dropped.
//   Output queue (empty/pop, o_word): each frame comes out as 16 words,
//   LSB first, one per accepted pop; latch_after is set on the 16th.
// Timing:
//   A frame's first bit becomes visible once the queue has registered the
//   frame and the shifter, when free, has loaded it from the queue.
//   The shift register gives one bit per cycle while pop is high, and the
//   next frame loads as the last bit is popped; the shift-out sets the
//   sustained refresh/clear rate. Writes produce nothing.
//   Two frames can wait in the queue, so intake keeps going while bits drain.
// Reset (synchronous, active low): cells go to space, scan digit to 0,
//   queue and shifter empty.
// Stall: with pop low the current bit holds; once the queue fills, full
//   rises and intake stops until bits drain.
// ----------------------------------------------------------------------------
module seven_segment_mux_serial_driver
    import ssd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      push,
    output logic      full,
    input  t_in_word  i_word,
    output logic      empty,
    input  logic      pop,
    output t_out_word o_word
);

    logic      w_accept;
    t_q_push   w_q_push;
    t_q_status w_q_status;
    t_frame    w_q_frame;
    logic      w_q_pop;

    // intake stalls only on a full frame queue
    assign full     = w_q_status.full;
    assign w_accept = push && !full;

    ssd_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_word   (i_word),
        .o_q_push (w_q_push)
    );

    ssd_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_push (w_q_push),
        .i_q_pop  (w_q_pop),
        .o_frame  (w_q_frame),
        .o_status (w_q_status)
    );

    ssd_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_frame    (w_q_frame),
        .i_q_status (w_q_status),
        .o_q_pop    (w_q_pop),
        .pop        (pop),
        .empty      (empty),
        .o_word     (o_word)
    );

`ifndef SYNTHESIS
    // never push into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_push.valid |-> !w_q_status.full)
        else $error("frame pushed into full queue");

    // refresh and clear always produce a frame
    a_frame_made: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_word.kind == KIND_REFRESH || i_word.kind == KIND_CLEAR))
        |-> w_q_push.valid)
        else $error("refresh/clear produced no frame");

    // writes and unused kinds produce none
    a_no_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_word.kind != KIND_REFRESH && i_word.kind != KIND_CLEAR)
        |-> !w_q_push.valid)
        else $error("frame produced by write item");

    // shifter only loads from a non-empty queue
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_pop |-> !w_q_status.empty)
        else $error("frame popped from empty queue");
`endif

endmodule

### tb/ssd_frame_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssd_frame_checker: scoreboard for the seven-segment serial driver
// Watches both queue ports, predicts every serial word from the accepted
// input words and compares each popped word against the oldest prediction.
// ----------------------------------------------------------------------------
module ssd_frame_checker
    import ssd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  logic      i_full,
    input  t_in_word  i_word,
    input  logic      i_empty,
    input  logic      i_pop,
    input  t_out_word i_out,
    output int        o_fail_count,
    output int        o_pending,
    output int        o_bits_seen
);

    // glyphs listed from index 0 at the top end
    localparam logic [79:0]  DIGIT_GLYPHS = {
        8'hFC, 8'h60, 8'hDA, 8'hF2, 8'h66, 8'hB6, 8'h3E, 8'hE0, 8'hFE, 8'hE6
    };
    localparam logic [207:0] ALPHA_GLYPHS = {
        8'hEE, 8'hFE, 8'h9C, 8'hFC, 8'h9E, 8'h8E, 8'hBE, 8'h6E, 8'h0C,
        8'h78, 8'h00, 8'h1C, 8'hEC, 8'h2E, 8'h3A, 8'hCE, 8'h3B, 8'hEE,
        8'hB6, 8'h0E, 8'h7C, 8'h38, 8'h38, 8'h00, 8'h66, 8'hDA
    };
    localparam int MAX_REPORTS = 10;

    logic [7:0] cell_text [4];
    logic [1:0] scan_pos;
    t_out_word  expected_bits [$];
    int         errors;
    int         bits_seen;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_bits_seen  = 0;
        errors       = 0;
        bits_seen    = 0;
    end

    // active-low segment pattern for one character
    function automatic logic [7:0] segments_for(input logic [7:0] c);
        int idx;
        idx = int'(c);
        if (c >= "0" && c <= "9") begin
            return ~DIGIT_GLYPHS[(9 - (idx - 48)) * 8 +: 8];
        end else if (c >= "a" && c <= "z") begin
            return ~ALPHA_GLYPHS[(25 - (idx - 97)) * 8 +: 8];
        end else if (c >= "A" && c <= "Z") begin
            return ~ALPHA_GLYPHS[(25 - (idx - 65)) * 8 +: 8];
        end else if (c == "-") begin
            return ~8'h02;
        end else if (c == ".") begin
            return ~8'h01;
        end else if (c == "_") begin
            return ~8'h10;
        end else if (c == " ") begin
            return 8'hFF;
        end
        return 8'd182;
    endfunction

    // LSB first, latch flag on the last bit
    task automatic queue_frame(input t_frame frame);
        t_out_word w;
        for (int i = 0; i < FRAME_BITS; i++) begin
            w.serial_bit  = frame[i];
            w.latch_after = (i == FRAME_BITS - 1);
            expected_bits.push_back(w);
        end
    endtask

    always @(posedge i_clk) begin : track
        t_out_word want;
        t_frame    frame;
        if (!i_rst_n) begin
            for (int k = 0; k < 4; k++) begin
                cell_text[k] = CHAR_SPACE;
            end
            scan_pos = 2'd0;
            expected_bits.delete();
        end else begin
            // pops first: a word pushed at this edge cannot already be out
            if (i_pop && !i_empty) begin
                bits_seen++;
                if (expected_bits.size() == 0) begin
                    errors++;
                    if (errors <= MAX_REPORTS) begin
                        $display("ERROR %0t: unexpected word serial_bit=%b latch_after=%b",
                                 $realtime, i_out.serial_bit, i_out.latch_after);
                    end
                end else begin
                    want = expected_bits.pop_front();
                    if (i_out.serial_bit !== want.serial_bit ||
                        i_out.latch_after !== want.latch_after) begin
                        errors++;
                        if (errors <= MAX_REPORTS) begin
                            $display({"ERROR %0t: bit %0d expected serial_bit=%b ",
                                      "latch_after=%b, got serial_bit=%b latch_after=%b"},
                                     $realtime, bits_seen, want.serial_bit,
                                     want.latch_after, i_out.serial_bit,
                                     i_out.latch_after);
                        end
                    end
                end
            end

            if (i_push && !i_full) begin
                case (i_word.kind)
                    KIND_WRITE: begin
                        cell_text[i_word.digit] = i_word.char_code;
                    end
                    KIND_REFRESH: begin
                        frame = {SEL_DIGIT0 << scan_pos, segments_for(cell_text[scan_pos])};
                        queue_frame(frame);
                        scan_pos = scan_pos + 2'd1;
                    end
                    KIND_CLEAR: begin
                        queue_frame('0);
                    end
                    default: ;
                endcase
            end
        end
        o_fail_count <= errors;
        o_pending    <= expected_bits.size();
        o_bits_seen  <= bits_seen;
    end

endmodule

### tb/seven_segment_mux_serial_driver_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seven_segment_mux_serial_driver_test: top of the driver testbench
// Drives write, refresh, clear and unused words into the input queue, pops
// serial words with random stalls, and leaves prediction to the checker.
// ----------------------------------------------------------------------------
module seven_segment_mux_serial_driver_test;
    import ssd_pkg::*;

    // kind 3 has no meaning in the block; it must be dropped silently
    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int RANDOM_WORDS = 420;
    localparam int IDLE_PCT     = 6;

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      push    = 1'b0;
    logic      pop     = 1'b0;
    t_in_word  i_word  = '0;
    logic      full;
    logic      empty;
    t_out_word o_word;

    int fail_count;
    int pending;
    int bits_seen;

    // stretch where neither side idles
    logic calm = 1'b0;

    int n_write   = 0;
    int n_refresh = 0;
    int n_clear   = 0;
    int n_ignored = 0;

    always #2 i_clk = ~i_clk;

    seven_segment_mux_serial_driver u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .push    (push),
        .full    (full),
        .i_word  (i_word),
        .empty   (empty),
        .pop     (pop),
        .o_word  (o_word)
    );

    ssd_frame_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_full       (full),
        .i_word       (i_word),
        .i_empty      (empty),
        .i_pop        (pop),
        .i_out        (o_word),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_bits_seen  (bits_seen)
    );

    // receiver: pop most cycles, stall now and then outside the calm stretch
    always @(posedge i_clk) begin
        if (!calm && $urandom_range(99) < IDLE_PCT) begin
            pop <= 1'b0;
        end else begin
            pop <= 1'b1;
        end
    end

    function automatic t_in_word make_word(input logic [1:0] kind, input logic [1:0] digit,
                                           input logic [7:0] char_code);
        t_in_word w;
        w.kind      = kind;
        w.digit     = digit;
        w.char_code = char_code;
        return w;
    endfunction

    // mostly printable glyph characters, the rest any byte
    function automatic logic [7:0] pick_char();
        case ($urandom_range(5))
            0:       return 8'(8'h30 + $urandom_range(9));
            1:       return 8'(8'h61 + $urandom_range(25));
            2:       return 8'(8'h41 + $urandom_range(25));
            3: begin
                case ($urandom_range(3))
                    0:       return "-";
                    1:       return ".";
                    2:       return "_";
                    default: return " ";
                endcase
            end
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // hold the word on the port until an edge sees full low
    task automatic send_word(input t_in_word w);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push   <= 1'b1;
        i_word <= w;
        @(posedge i_clk);
        while (full) begin
            @(posedge i_clk);
        end
        case (w.kind)
            KIND_WRITE:   n_write++;
            KIND_REFRESH: n_refresh++;
            KIND_CLEAR:   n_clear++;
            default:      n_ignored++;
        endcase
    endtask

    // run limit, far beyond the slowest legal run
    initial begin
        #2_000_000;
        $display("timeout: %0d serial words still expected", pending);
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        int       counted;
        int       r;
        t_in_word w;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // --- directed part ---
        // refresh straight out of reset: blank digit 0
        send_word(make_word(KIND_REFRESH, 2'd0, 8'h00));
        // clear and dropped kind with every unused field bit set
        send_word(make_word(KIND_CLEAR, 2'd3, 8'hFF));
        send_word(make_word(KIND_UNUSED, 2'd3, 8'hFF));
        // range ends of digits and both letter cases
        send_word(make_word(KIND_WRITE, 2'd0, "0"));
        send_word(make_word(KIND_WRITE, 2'd1, "9"));
        send_word(make_word(KIND_WRITE, 2'd2, "A"));
        send_word(make_word(KIND_WRITE, 2'd3, "z"));
        repeat (4) send_word(make_word(KIND_REFRESH, 2'd3, 8'hFF));
        // punctuation glyphs and the top byte
        send_word(make_word(KIND_WRITE, 2'd0, "-"));
        send_word(make_word(KIND_WRITE, 2'd1, "."));
        send_word(make_word(KIND_WRITE, 2'd2, "_"));
        send_word(make_word(KIND_WRITE, 2'd3, 8'hFF));
        repeat (4) send_word(make_word(KIND_REFRESH, 2'd0, 8'h00));
        // the other letter ends, zero byte, and a neighbor of the letter range
        send_word(make_word(KIND_WRITE, 2'd0, "a"));
        send_word(make_word(KIND_WRITE, 2'd1, "Z"));
        send_word(make_word(KIND_WRITE, 2'd2, 8'h00));
        send_word(make_word(KIND_WRITE, 2'd3, "@"));
        repeat (4) send_word(make_word(KIND_REFRESH, 2'd1, 8'h5A));

        // --- random part; dropped words do not count ---
        counted = 0;
        while (counted < RANDOM_WORDS) begin
            calm = (counted >= 150 && counted < 270);
            r = $urandom_range(99);
            w.digit     = 2'($urandom_range(3));
            w.char_code = pick_char();
            if (r < 40) begin
                w.kind = KIND_WRITE;
            end else if (r < 82) begin
                w.kind = KIND_REFRESH;
            end else if (r < 94) begin
                w.kind = KIND_CLEAR;
            end else begin
                w.kind = KIND_UNUSED;
            end
            send_word(w);
            if (w.kind != KIND_UNUSED) begin
                counted++;
            end
        end
        calm = 1'b0;
        push <= 1'b0;

        // let the checker count the last accepted word, drain, then give a
        // stray word time to show up
        @(posedge i_clk);
        wait (pending == 0);
        repeat (40) @(posedge i_clk);

        $display("Sent %0d writes, %0d refresh and %0d clear words, %0d dropped words",
                 n_write, n_refresh, n_clear, n_ignored);
        $display("Compared %0d serial words; %0d mismatches", bits_seen, fail_count);
        if (fail_count == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
